// ----- src/parent_linked_key_table_assert.svh -----
// Assertion macros for the parent-linked key table.
// Included by the top level; no other dependencies.
`ifndef PARENT_LINKED_KEY_TABLE_ASSERT_SVH
`define PARENT_LINKED_KEY_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
`define PLKT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
`define PLKT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PLKT_ASSERT_IMP(label, clk, rstn, ante, cons, msg)
`define PLKT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- src/plkt_pkg.sv -----
// Shared types and constants for the parent-linked key table.
// No dependencies.
package plkt_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int KEY_W           = 32;
    localparam int SLOT_W          = 5;
    localparam int ENTRY_W         = 2 * KEY_W;
    localparam int RESULT_CAP      = 32;
    localparam int MATCH_W         = $clog2(RESULT_CAP + 1);
    localparam int IN_TDATA_W      = 72;
    localparam int OUT_TDATA_W     = 40;

    typedef enum logic [1:0] {
        CMD_INSERT   = 2'd0,
        CMD_DELETE   = 2'd1,
        CMD_LOOKUP   = 2'd2,
        CMD_CHILDREN = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_REJECT = 2'd1,
        ST_FULL   = 2'd2,
        ST_MISS   = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t                     cmd;
        logic signed [KEY_W-1:0]  key;
        logic signed [KEY_W-1:0]  parent_key;
        logic        [SLOT_W-1:0] position;
    } req_t;

    typedef struct packed {
        status_t                  status;
        logic        [SLOT_W-1:0] slot;
        logic signed [KEY_W-1:0]  child_key;
        logic                     last;
    } res_t;

endpackage

// ----- src/plkt_ram.sv -----
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module plkt_ram #(
    parameter int DEPTH = 32,
    parameter int WIDTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/plkt_seq.sv -----
// Command sequencer: scans the entry RAM one slot per read, updates it and
// produces result words. Depends on plkt_pkg.
module plkt_seq #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  req_valid,
    output logic                                  req_ready,
    input  plkt_pkg::req_t                        req,
    output logic                                  res_valid,
    input  logic                                  res_ready,
    output plkt_pkg::res_t                        res,
    output logic                                  wr_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]        wr_addr,
    output logic [plkt_pkg::ENTRY_W-1:0]          wr_data,
    output logic                                  rd_en,
    output logic [$clog2(TABLE_DEPTH)-1:0]        rd_addr,
    input  logic [plkt_pkg::ENTRY_W-1:0]          rd_data,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]      fill
);
    import plkt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    typedef enum logic [1:0] {S_IDLE, S_RD, S_EV, S_FIN} state_t;
    typedef enum logic [1:0] {PH_GONE, PH_CLR, PH_MOVE} phase_t;

    state_t              state_reg;
    phase_t              phase_reg;
    cmd_t                cmd_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [KEY_W-1:0]    par_reg;
    logic [SLOT_W-1:0]   pos_reg;
    logic [IDX_W-1:0]    addr_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [MATCH_W-1:0]  nmatch_reg;
    logic                fk_reg;
    logic                fp_reg;
    logic                hit_reg;
    logic                err_reg;
    logic [KEY_W-1:0]    gone_reg;
    logic [SLOT_W-1:0]   pend_slot_reg;
    logic [KEY_W-1:0]    pend_key_reg;
    logic                out_valid_reg;
    res_t                out_reg;

    logic              out_free;
    logic              out_valid_next;
    logic [IDX_W-1:0]  last_idx;
    logic              at_end;
    logic [KEY_W-1:0]  rk;
    logic [KEY_W-1:0]  rp;
    logic              full;
    logic              ins_bad;
    logic              child_hit;
    logic              pos_bad;
    res_t              fin_res;

    assign out_free  = !out_valid_reg || res_ready;
    assign last_idx  = IDX_W'(cnt_reg - CNT_W'(1));
    assign at_end    = (addr_reg == last_idx);
    assign rk        = rd_data[KEY_W-1:0];
    assign rp        = rd_data[ENTRY_W-1:KEY_W];
    assign full      = (cnt_reg == CNT_W'(TABLE_DEPTH));
    assign ins_bad   = fk_reg || ((par_reg != '0) && !fp_reg);
    assign child_hit = (rp == key_reg);
    assign pos_bad   = (CMP_W'(req.position) >= CMP_W'(cnt_reg));

    // A word is loaded when the command finishes or when a held match is pushed out.
    assign out_valid_next = (out_valid_reg && !res_ready)
                         || (out_free && ((state_reg == S_FIN)
                             || (state_reg == S_EV && cmd_reg == CMD_CHILDREN
                                 && child_hit && nmatch_reg != '0)));

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign fill      = cnt_reg;
    assign rd_en     = (state_reg == S_RD);
    assign rd_addr   = addr_reg;

    // The final word of every command; the children list closes with its held match, or with a miss when none matched.
    always_comb begin
        fin_res = '{status: ST_OK, slot: '0, child_key: '0, last: 1'b1};
        unique case (cmd_reg)
            CMD_INSERT: begin
                if (ins_bad) begin
                    fin_res.status = ST_REJECT;
                end else if (full) begin
                    fin_res.status = ST_FULL;
                end else begin
                    fin_res.slot = SLOT_W'(cnt_reg);
                end
            end
            CMD_DELETE: begin
                if (err_reg) begin
                    fin_res.status = ST_MISS;
                end
            end
            CMD_LOOKUP: begin
                if (hit_reg) begin
                    fin_res.slot = pend_slot_reg;
                end else begin
                    fin_res.status = ST_MISS;
                end
            end
            CMD_CHILDREN: begin
                if (nmatch_reg == '0) begin
                    fin_res.status = ST_MISS;
                end else begin
                    fin_res.slot      = pend_slot_reg;
                    fin_res.child_key = pend_key_reg;
                end
            end
            default: fin_res.status = ST_MISS;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = rd_data;
        if (state_reg == S_EV && cmd_reg == CMD_DELETE && phase_reg == PH_CLR
            && rp == gone_reg) begin
            wr_en   = 1'b1;
            wr_data = {{KEY_W{1'b0}}, rk};
        end else if (state_reg == S_EV && cmd_reg == CMD_DELETE
                     && phase_reg == PH_MOVE) begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(pos_reg);
        end else if (state_reg == S_FIN && out_free && cmd_reg == CMD_INSERT
                     && !ins_bad && !full) begin
            wr_en   = 1'b1;
            wr_addr = IDX_W'(cnt_reg);
            wr_data = {par_reg, key_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            unique case (state_reg)
                S_IDLE: begin
                    if (req_valid) begin
                        cmd_reg    <= req.cmd;
                        key_reg    <= req.key;
                        par_reg    <= req.parent_key;
                        pos_reg    <= req.position;
                        nmatch_reg <= '0;
                        fk_reg     <= 1'b0;
                        fp_reg     <= 1'b0;
                        hit_reg    <= 1'b0;
                        err_reg    <= pos_bad;
                        phase_reg  <= PH_GONE;
                        addr_reg   <= (req.cmd == CMD_DELETE) ? IDX_W'(req.position) : '0;
                        if (req.cmd == CMD_DELETE) begin
                            if (pos_bad) begin
                                state_reg <= S_FIN;
                            end else begin
                                state_reg <= S_RD;
                            end
                        end else if (cnt_reg == '0) begin
                            state_reg <= S_FIN;
                        end else begin
                            state_reg <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    state_reg <= S_EV;
                end
                S_EV: begin
                    unique case (cmd_reg)
                        CMD_INSERT: begin
                            fk_reg <= fk_reg || (rk == key_reg);
                            fp_reg <= fp_reg || (rk == par_reg);
                            addr_reg  <= addr_reg + IDX_W'(1);
                            state_reg <= at_end ? S_FIN : S_RD;
                        end
                        CMD_LOOKUP: begin
                            if (rk == key_reg) begin
                                hit_reg       <= 1'b1;
                                pend_slot_reg <= SLOT_W'(addr_reg);
                                state_reg     <= S_FIN;
                            end else begin
                                addr_reg  <= addr_reg + IDX_W'(1);
                                state_reg <= at_end ? S_FIN : S_RD;
                            end
                        end
                        CMD_CHILDREN: begin
                            // A match is held back one step so the last one can be flagged.
                            if (!child_hit) begin
                                addr_reg  <= addr_reg + IDX_W'(1);
                                state_reg <= at_end ? S_FIN : S_RD;
                            end else if (nmatch_reg == '0 || out_free) begin
                                if (nmatch_reg != '0) begin
                                    out_reg <= '{status: ST_OK, slot: pend_slot_reg,
                                                 child_key: pend_key_reg, last: 1'b0};
                                end
                                pend_slot_reg <= SLOT_W'(addr_reg);
                                pend_key_reg  <= rk;
                                nmatch_reg    <= nmatch_reg + MATCH_W'(1);
                                addr_reg      <= addr_reg + IDX_W'(1);
                                if (at_end || nmatch_reg == MATCH_W'(RESULT_CAP - 1)) begin
                                    state_reg <= S_FIN;
                                end else begin
                                    state_reg <= S_RD;
                                end
                            end
                        end
                        CMD_DELETE: begin
                            unique case (phase_reg)
                                PH_GONE: begin
                                    gone_reg  <= rk;
                                    addr_reg  <= '0;
                                    phase_reg <= PH_CLR;
                                    state_reg <= S_RD;
                                end
                                PH_CLR: begin
                                    // The final entry is read only after its parent
                                    // may have been cleared by this pass.
                                    if (at_end) begin
                                        phase_reg <= PH_MOVE;
                                    end else begin
                                        addr_reg <= addr_reg + IDX_W'(1);
                                    end
                                    state_reg <= S_RD;
                                end
                                PH_MOVE: begin
                                    cnt_reg   <= cnt_reg - CNT_W'(1);
                                    state_reg <= S_FIN;
                                end
                                default: state_reg <= S_FIN;
                            endcase
                        end
                        default: state_reg <= S_FIN;
                    endcase
                end
                S_FIN: begin
                    if (out_free) begin
                        out_reg <= fin_res;
                        if (cmd_reg == CMD_INSERT && !ins_bad && !full) begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- src/parent_linked_key_table.sv -----
// Parent-linked key table: up to TABLE_DEPTH unique keys, each with a parent key
// (zero for none), held in one RAM of {parent, key} words in slots 0 .. count-1.
// Commands are taken one at a time and each walks the RAM slot by slot
// (read, then evaluate). Delete makes one read of the victim, a full pass clearing
// its children's parent links, and a read and write moving the final entry into
// the hole. The children walk may also stall on the output. The RAM read port
// sets the pace. Results leave through an output register, so a finished result
// may wait on m_tready without holding up the next command's start.
`include "parent_linked_key_table_assert.svh"

module parent_linked_key_table #(
    parameter int TABLE_DEPTH = plkt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // key [31:0], parent_key [63:32], position [68:64], zero fill above
    input  logic [plkt_pkg::IN_TDATA_W-1:0]   s_tdata,
    // cmd [1:0]
    input  logic [1:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // slot [4:0], child_key [36:5], zero fill above
    output logic [plkt_pkg::OUT_TDATA_W-1:0]  m_tdata,
    // status [1:0]
    output logic [1:0]                        m_tuser,
    output logic                              m_tlast
);
    import plkt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int PAD_W = OUT_TDATA_W - KEY_W - SLOT_W;

    req_t               req;
    res_t               res;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic [CNT_W-1:0]   fill;

    assign req.cmd        = cmd_t'(s_tuser);
    assign req.key        = s_tdata[KEY_W-1:0];
    assign req.parent_key = s_tdata[2*KEY_W-1:KEY_W];
    assign req.position   = s_tdata[2*KEY_W+SLOT_W-1:2*KEY_W];

    plkt_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    plkt_seq #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req       (req),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_data   (rd_data),
        .fill      (fill)
    );

    assign m_tdata = {{PAD_W{1'b0}}, res.child_key, res.slot};
    assign m_tuser = res.status;
    assign m_tlast = res.last;

    `PLKT_ASSERT_IMP(a_fill_bound, aclk, aresetn, 1'b1, fill <= CNT_W'(TABLE_DEPTH), "entry count above table depth")
    `PLKT_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready, "new command taken while busy")
    `PLKT_ASSERT_IMP(a_error_is_last, aclk, aresetn, m_tvalid && m_tuser != ST_OK, m_tlast, "error word not marked last")

endmodule
